// ----- hdl/rphr_pkg.sv -----
// Shared types, register map, datapath operation codes and status bundle for the R-peak unit.
package rphr_pkg;

	localparam int REG_W     = 10;
	localparam int CFG_IDX_W = 3;

	typedef logic [REG_W-1:0]     reg_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_WINDOW_LENGTH = 3'd0;
	localparam cfg_idx_t REG_STEP_LENGTH   = 3'd1;
	localparam cfg_idx_t REG_VALID_START   = 3'd2;
	localparam cfg_idx_t REG_VALID_END     = 3'd3;
	localparam cfg_idx_t REG_SAMP_HZ       = 3'd4;
	localparam cfg_idx_t REG_R_WIDTH_MAX   = 3'd5;

	localparam reg_t RST_WINDOW_LENGTH = 10'd80;
	localparam reg_t RST_STEP_LENGTH   = 10'd16;
	localparam reg_t RST_VALID_START   = 10'd24;
	localparam reg_t RST_VALID_END     = 10'd56;
	localparam reg_t RST_SAMP_HZ       = 10'd160;
	localparam reg_t RST_R_WIDTH_MAX   = 10'd9;

	localparam logic [15:0] HR_MAX = 16'hFFFF;

	typedef struct packed {
		reg_t window_length;
		reg_t step_length;
		reg_t valid_start;
		reg_t valid_end;
		reg_t samp_hz;
		reg_t r_width_max;
	} cfg_t;

	typedef logic [4:0] op_t;

	localparam op_t OP_NONE   = 5'd0;
	localparam op_t OP_LOAD   = 5'd1;
	localparam op_t OP_INIT   = 5'd2;
	localparam op_t OP_WIN    = 5'd3;
	localparam op_t OP_MX     = 5'd4;
	localparam op_t OP_JINIT  = 5'd5;
	localparam op_t OP_KJM1   = 5'd6;
	localparam op_t OP_PREV   = 5'd7;
	localparam op_t OP_PV     = 5'd8;
	localparam op_t OP_PSET   = 5'd9;
	localparam op_t OP_NEXTJ  = 5'd10;
	localparam op_t OP_KDEC   = 5'd11;
	localparam op_t OP_LMIN   = 5'd12;
	localparam op_t OP_KJ1    = 5'd13;
	localparam op_t OP_RMIN   = 5'd14;
	localparam op_t OP_LOSET  = 5'd15;
	localparam op_t OP_KLO    = 5'd16;
	localparam op_t OP_LODEC  = 5'd17;
	localparam op_t OP_KINC   = 5'd18;
	localparam op_t OP_ACCEPT = 5'd19;
	localparam op_t OP_STEP   = 5'd20;
	localparam op_t OP_RATE   = 5'd21;
	localparam op_t OP_MUL    = 5'd22;
	localparam op_t OP_DIVGO  = 5'd23;
	localparam op_t OP_DIVEND = 5'd24;
	localparam op_t OP_CLR    = 5'd25;

	typedef struct packed {
		logic w_short;
		logic win_ok;
		logic mx_last;
		logic j_ok;
		logic cand_ok;
		logic k_gt_i;
		logic k_lt_end;
		logic above_pv;
		logic prom_ok;
		logic lo_gt_i;
		logic below;
		logic wid_ok;
		logic rate_zero;
		logic rate_sat;
		logic div_done;
	} sts_t;

endpackage

// ----- hdl/rphr_div.sv -----
// Restoring divider, one quotient bit per cycle.
module rphr_div #(
	parameter int W = 26
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic [W-1:0] quo,
	output logic         done
);

	localparam int CNTW = $clog2(W + 1);

	logic [W-1:0]    rem_q;
	logic [W-1:0]    quo_q;
	logic [W-1:0]    den_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [W:0]      rem_sh;
	logic            fits;

	assign rem_sh = {rem_q, quo_q[W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= fits ? W'(rem_sh - {1'b0, den_q}) : rem_sh[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// ----- hdl/rphr_dp.sv -----
// Datapath: sample memory, scan pointers, window maximum, peak tests and heart-rate arithmetic.
module rphr_dp #(
	parameter int MAX_SAMPLES  = 1024,
	parameter int MAX_PEAKS    = 50,
	parameter int SAMPLE_WIDTH = 24,
	localparam int CW = $clog2(MAX_PEAKS + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rphr_pkg::op_t           op,
	input  rphr_pkg::cfg_t          cfg,
	input  logic [SAMPLE_WIDTH-1:0] sample,
	output rphr_pkg::sts_t          sts,
	output logic [15:0]             beat_rate,
	output logic [CW-1:0]           peak_count
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int LW = $clog2(MAX_SAMPLES + 1);
	localparam int XW = ((LW > 10) ? LW : 10) + 1;
	localparam int PW = CW + 10;
	localparam int NW = CW + 16;
	localparam int DW = NW + 2;

	logic [SW-1:0] mem [MAX_SAMPLES];

	logic [LW-1:0]        n_q;
	logic [XW-1:0]        i_q, j_q, k_q, lo_q;
	logic signed [SW-1:0] rd_q, mx_q, pv_q, prev_q, lmin_q, rmin_q;
	logic [CW-1:0]        cnt_q;
	logic [AW-1:0]        first_q, last_q;
	logic [PW-1:0]        prod_q;
	logic [NW-1:0]        num_q;
	logic [15:0]          hr_q;

	logic [XW-1:0]        wend, step, off;
	logic signed [SW:0]   mx_w, two_pv, two_rd, prom_v;
	logic signed [SW-1:0] maxmin;
	logic [AW-1:0]        den;
	logic [DW-1:0]        div_num, div_den, quo;
	logic                 div_done;

	assign wend   = i_q + XW'(cfg.window_length);
	assign step   = (cfg.step_length == '0) ? XW'(1) : XW'(cfg.step_length);
	assign off    = j_q - i_q;
	assign mx_w   = {mx_q[SW-1], mx_q};
	assign two_pv = {pv_q, 1'b0};
	assign two_rd = {rd_q, 1'b0};
	assign maxmin = (lmin_q > rmin_q) ? lmin_q : rmin_q;
	assign prom_v = {pv_q[SW-1], pv_q} - {maxmin[SW-1], maxmin};
	assign den    = last_q - first_q;

	assign div_num = DW'({num_q, 1'b0}) + DW'(den);
	assign div_den = DW'({den, 1'b0});

	always_comb begin
		sts.w_short   = cfg.window_length < rphr_pkg::reg_t'(3);
		sts.win_ok    = wend < XW'(n_q);
		sts.mx_last   = (k_q + 1'b1) == wend;
		sts.j_ok      = (j_q + 1'b1) < wend;
		sts.cand_ok   = (two_pv > mx_w) && (pv_q > prev_q) && (pv_q > rd_q)
			&& (off >= XW'(cfg.valid_start)) && (off < XW'(cfg.valid_end))
			&& (cnt_q < CW'(MAX_PEAKS))
			&& !((cnt_q != '0) && (last_q == j_q[AW-1:0]));
		sts.k_gt_i    = k_q > i_q;
		sts.k_lt_end  = k_q < wend;
		sts.above_pv  = rd_q > pv_q;
		sts.prom_ok   = prom_v > mx_w;
		sts.lo_gt_i   = lo_q > i_q;
		sts.below     = two_rd < mx_w;
		sts.wid_ok    = (k_q - lo_q) < XW'(cfg.r_width_max);
		sts.rate_zero = (cnt_q < CW'(2)) || (cfg.samp_hz == '0) || (last_q < first_q);
		sts.rate_sat  = last_q == first_q;
		sts.div_done  = div_done;
	end

	// single write port for loading, one registered read port for every scan
	always_ff @(posedge clk) begin
		if (op == rphr_pkg::OP_LOAD && n_q < LW'(MAX_SAMPLES))
			mem[n_q[AW-1:0]] <= sample;
		rd_q <= mem[k_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			cnt_q   <= '0;
			first_q <= '0;
			last_q  <= '0;
		end else begin
			unique case (op)
				rphr_pkg::OP_LOAD:   if (n_q < LW'(MAX_SAMPLES)) n_q <= n_q + 1'b1;
				rphr_pkg::OP_INIT: begin
					cnt_q   <= '0;
					first_q <= '0;
					last_q  <= '0;
				end
				rphr_pkg::OP_ACCEPT: begin
					if (cnt_q == '0) first_q <= j_q[AW-1:0];
					last_q <= j_q[AW-1:0];
					cnt_q  <= cnt_q + 1'b1;
				end
				rphr_pkg::OP_CLR:    n_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			rphr_pkg::OP_INIT:   i_q <= '0;
			rphr_pkg::OP_WIN:    k_q <= i_q;
			rphr_pkg::OP_MX: begin
				if (k_q == i_q || rd_q > mx_q) mx_q <= rd_q;
				k_q <= k_q + 1'b1;
			end
			rphr_pkg::OP_JINIT:  j_q <= i_q + 1'b1;
			rphr_pkg::OP_KJM1:   k_q <= j_q - 1'b1;
			rphr_pkg::OP_PREV: begin
				prev_q <= rd_q;
				k_q    <= j_q;
			end
			rphr_pkg::OP_PV: begin
				pv_q <= rd_q;
				k_q  <= j_q + 1'b1;
			end
			rphr_pkg::OP_PSET: begin
				lmin_q <= pv_q;
				rmin_q <= pv_q;
				k_q    <= j_q;
			end
			rphr_pkg::OP_NEXTJ:  j_q <= j_q + 1'b1;
			rphr_pkg::OP_KDEC:   k_q <= k_q - 1'b1;
			rphr_pkg::OP_LMIN:   if (rd_q < lmin_q) lmin_q <= rd_q;
			rphr_pkg::OP_KJ1:    k_q <= j_q + 1'b1;
			rphr_pkg::OP_RMIN: begin
				if (rd_q < rmin_q) rmin_q <= rd_q;
				k_q <= k_q + 1'b1;
			end
			rphr_pkg::OP_LOSET:  lo_q <= j_q;
			rphr_pkg::OP_KLO:    k_q <= lo_q - 1'b1;
			rphr_pkg::OP_LODEC:  lo_q <= k_q;
			rphr_pkg::OP_KINC:   k_q <= k_q + 1'b1;
			rphr_pkg::OP_ACCEPT: j_q <= j_q + 1'b1;
			rphr_pkg::OP_STEP:   i_q <= i_q + step;
			rphr_pkg::OP_RATE: begin
				if (sts.rate_zero)     hr_q <= '0;
				else if (sts.rate_sat) hr_q <= rphr_pkg::HR_MAX;
				prod_q <= (PW'(cnt_q) - 1'b1) * PW'(cfg.samp_hz);
			end
			rphr_pkg::OP_MUL:    num_q <= (NW'(prod_q) << 6) - (NW'(prod_q) << 2);
			rphr_pkg::OP_DIVEND: hr_q <= (quo > DW'(rphr_pkg::HR_MAX)) ? rphr_pkg::HR_MAX : quo[15:0];
			default: ;
		endcase
	end

	rphr_div #(.W(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (op == rphr_pkg::OP_DIVGO),
		.num    (div_num),
		.den    (div_den),
		.quo    (quo),
		.done   (div_done)
	);

	assign beat_rate  = hr_q;
	assign peak_count = cnt_q;

endmodule

// ----- hdl/rphr_ctrl.sv -----
// Controller: sequences loading, window scans, peak tests and the rate computation.
module rphr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           is_last,
	input  rphr_pkg::sts_t sts,
	output rphr_pkg::op_t  op,
	output logic           busy,
	output logic           done
);

	localparam logic [5:0] S_IDLE  = 6'd0;
	localparam logic [5:0] S_INIT  = 6'd1;
	localparam logic [5:0] S_WIN   = 6'd2;
	localparam logic [5:0] S_MX_RD = 6'd3;
	localparam logic [5:0] S_MX_X  = 6'd4;
	localparam logic [5:0] S_JINIT = 6'd5;
	localparam logic [5:0] S_J_CHK = 6'd6;
	localparam logic [5:0] S_C0_RD = 6'd7;
	localparam logic [5:0] S_C0_X  = 6'd8;
	localparam logic [5:0] S_C1_RD = 6'd9;
	localparam logic [5:0] S_C1_X  = 6'd10;
	localparam logic [5:0] S_C2_RD = 6'd11;
	localparam logic [5:0] S_C2_X  = 6'd12;
	localparam logic [5:0] S_PL_CK = 6'd13;
	localparam logic [5:0] S_PL_RD = 6'd14;
	localparam logic [5:0] S_PL_X  = 6'd15;
	localparam logic [5:0] S_PR_IN = 6'd16;
	localparam logic [5:0] S_PR_CK = 6'd17;
	localparam logic [5:0] S_PR_RD = 6'd18;
	localparam logic [5:0] S_PR_X  = 6'd19;
	localparam logic [5:0] S_PROM  = 6'd20;
	localparam logic [5:0] S_WL_CK = 6'd21;
	localparam logic [5:0] S_WL_RD = 6'd22;
	localparam logic [5:0] S_WL_X  = 6'd23;
	localparam logic [5:0] S_WR_CK = 6'd24;
	localparam logic [5:0] S_WR_RD = 6'd25;
	localparam logic [5:0] S_WR_X  = 6'd26;
	localparam logic [5:0] S_WID   = 6'd27;
	localparam logic [5:0] S_RATE  = 6'd28;
	localparam logic [5:0] S_MUL   = 6'd29;
	localparam logic [5:0] S_DIVGO = 6'd30;
	localparam logic [5:0] S_DIVW  = 6'd31;
	localparam logic [5:0] S_OUT   = 6'd32;

	logic [5:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		op      = rphr_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: if (start) begin
				op = rphr_pkg::OP_LOAD;
				if (is_last) state_d = S_INIT;
			end
			S_INIT: begin
				op      = rphr_pkg::OP_INIT;
				state_d = sts.w_short ? S_RATE : S_WIN;
			end
			S_WIN: if (sts.win_ok) begin
				op      = rphr_pkg::OP_WIN;
				state_d = S_MX_RD;
			end else begin
				state_d = S_RATE;
			end
			S_MX_RD: state_d = S_MX_X;
			S_MX_X: begin
				op      = rphr_pkg::OP_MX;
				state_d = sts.mx_last ? S_JINIT : S_MX_RD;
			end
			S_JINIT: begin
				op      = rphr_pkg::OP_JINIT;
				state_d = S_J_CHK;
			end
			S_J_CHK: if (sts.j_ok) begin
				op      = rphr_pkg::OP_KJM1;
				state_d = S_C0_RD;
			end else begin
				op      = rphr_pkg::OP_STEP;
				state_d = S_WIN;
			end
			S_C0_RD: state_d = S_C0_X;
			S_C0_X: begin
				op      = rphr_pkg::OP_PREV;
				state_d = S_C1_RD;
			end
			S_C1_RD: state_d = S_C1_X;
			S_C1_X: begin
				op      = rphr_pkg::OP_PV;
				state_d = S_C2_RD;
			end
			S_C2_RD: state_d = S_C2_X;
			S_C2_X: if (sts.cand_ok) begin
				op      = rphr_pkg::OP_PSET;
				state_d = S_PL_CK;
			end else begin
				op      = rphr_pkg::OP_NEXTJ;
				state_d = S_J_CHK;
			end
			S_PL_CK: if (sts.k_gt_i) begin
				op      = rphr_pkg::OP_KDEC;
				state_d = S_PL_RD;
			end else begin
				state_d = S_PR_IN;
			end
			S_PL_RD: state_d = S_PL_X;
			S_PL_X: begin
				op      = rphr_pkg::OP_LMIN;
				state_d = sts.above_pv ? S_PR_IN : S_PL_CK;
			end
			S_PR_IN: begin
				op      = rphr_pkg::OP_KJ1;
				state_d = S_PR_CK;
			end
			S_PR_CK: state_d = sts.k_lt_end ? S_PR_RD : S_PROM;
			S_PR_RD: state_d = S_PR_X;
			S_PR_X: begin
				op      = rphr_pkg::OP_RMIN;
				state_d = sts.above_pv ? S_PROM : S_PR_CK;
			end
			S_PROM: if (sts.prom_ok) begin
				op      = rphr_pkg::OP_LOSET;
				state_d = S_WL_CK;
			end else begin
				op      = rphr_pkg::OP_NEXTJ;
				state_d = S_J_CHK;
			end
			S_WL_CK: if (sts.lo_gt_i) begin
				op      = rphr_pkg::OP_KLO;
				state_d = S_WL_RD;
			end else begin
				op      = rphr_pkg::OP_KJ1;
				state_d = S_WR_CK;
			end
			S_WL_RD: state_d = S_WL_X;
			S_WL_X: if (sts.below) begin
				op      = rphr_pkg::OP_KJ1;
				state_d = S_WR_CK;
			end else begin
				op      = rphr_pkg::OP_LODEC;
				state_d = S_WL_CK;
			end
			S_WR_CK: state_d = sts.k_lt_end ? S_WR_RD : S_WID;
			S_WR_RD: state_d = S_WR_X;
			S_WR_X: if (sts.below) begin
				state_d = S_WID;
			end else begin
				op      = rphr_pkg::OP_KINC;
				state_d = S_WR_CK;
			end
			S_WID: begin
				op      = sts.wid_ok ? rphr_pkg::OP_ACCEPT : rphr_pkg::OP_NEXTJ;
				state_d = S_J_CHK;
			end
			S_RATE: begin
				op      = rphr_pkg::OP_RATE;
				state_d = (sts.rate_zero || sts.rate_sat) ? S_OUT : S_MUL;
			end
			S_MUL: begin
				op      = rphr_pkg::OP_MUL;
				state_d = S_DIVGO;
			end
			S_DIVGO: begin
				op      = rphr_pkg::OP_DIVGO;
				state_d = S_DIVW;
			end
			S_DIVW: if (sts.div_done) begin
				op      = rphr_pkg::OP_DIVEND;
				state_d = S_OUT;
			end
			S_OUT: begin
				op      = rphr_pkg::OP_CLR;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_OUT;

endmodule

// ----- hdl/r_peak_heart_rate_unit.sv -----
// Top level of the R-peak detector and heart-rate estimator.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+----------------------------------
//  request   | in        | start high, busy low    | sample, is_last
//  result    | out       | done, one-cycle strobe  | beat_rate, peak_count
//  config    | in        | cfg_we                  | cfg_index, cfg_wdata
//
// Each sample request is taken as it is offered and the block stays ready. A
// request with is_last runs the search: per window a scan for the maximum,
// then at each position the peak test and, for a candidate, the prominence
// and width scans, then, when needed, the rate divide; the single read port
// of the sample memory, with its registered output, sets the pace of the
// scans. busy is high from the closing request until the done strobe. Reset
// clears the controller, counts and configuration; the memory is not
// cleared. The receiver cannot stall: results appear for exactly one cycle.
module r_peak_heart_rate_unit #(
	parameter int MAX_SAMPLES  = 1024,
	parameter int MAX_PEAKS    = 50,
	parameter int SAMPLE_WIDTH = 24,
	localparam int PCW = $clog2(MAX_PEAKS + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [SAMPLE_WIDTH-1:0]  sample,
	input  logic                     is_last,
	output logic                     done,
	output logic [15:0]              beat_rate,
	output logic [PCW-1:0]           peak_count,
	input  logic                     cfg_we,
	input  rphr_pkg::cfg_idx_t       cfg_index,
	input  rphr_pkg::reg_t           cfg_wdata
);

	rphr_pkg::cfg_t cfg_q;
	rphr_pkg::op_t  op;
	rphr_pkg::sts_t sts;

	// hold configuration; indexes beyond the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_length <= rphr_pkg::RST_WINDOW_LENGTH;
			cfg_q.step_length   <= rphr_pkg::RST_STEP_LENGTH;
			cfg_q.valid_start   <= rphr_pkg::RST_VALID_START;
			cfg_q.valid_end     <= rphr_pkg::RST_VALID_END;
			cfg_q.samp_hz       <= rphr_pkg::RST_SAMP_HZ;
			cfg_q.r_width_max   <= rphr_pkg::RST_R_WIDTH_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rphr_pkg::REG_WINDOW_LENGTH: cfg_q.window_length <= cfg_wdata;
				rphr_pkg::REG_STEP_LENGTH:   cfg_q.step_length   <= cfg_wdata;
				rphr_pkg::REG_VALID_START:   cfg_q.valid_start   <= cfg_wdata;
				rphr_pkg::REG_VALID_END:     cfg_q.valid_end     <= cfg_wdata;
				rphr_pkg::REG_SAMP_HZ:       cfg_q.samp_hz       <= cfg_wdata;
				rphr_pkg::REG_R_WIDTH_MAX:   cfg_q.r_width_max   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// controller issues one datapath operation per cycle from its state
	rphr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.is_last (is_last),
		.sts     (sts),
		.op      (op),
		.busy    (busy),
		.done    (done)
	);

	rphr_dp #(
		.MAX_SAMPLES  (MAX_SAMPLES),
		.MAX_PEAKS    (MAX_PEAKS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.cfg        (cfg_q),
		.sample     (sample),
		.sts        (sts),
		.beat_rate  (beat_rate),
		.peak_count (peak_count)
	);

endmodule

// ----- hdl/rphr_chk.sv -----
// Port-level checker for the R-peak unit and its bind.
module rphr_chk #(
	parameter int PCW = 6
) (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           is_last,
	input logic           done,
	input logic [15:0]    beat_rate,
	input logic [PCW-1:0] peak_count
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result strobe while idle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !is_last) |=> !busy)
		else $error("plain sample request left the block busy");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && is_last) |=> busy)
		else $error("closing request did not start the search");

	a_hr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && peak_count < PCW'(2)) |-> beat_rate == 16'd0)
		else $error("heart rate set with fewer than two peaks");

endmodule

bind r_peak_heart_rate_unit rphr_chk #(.PCW(PCW)) u_rphr_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.is_last    (is_last),
	.done       (done),
	.beat_rate  (beat_rate),
	.peak_count (peak_count)
);
